>>> hw/rtl/ubfe_pkg.sv
// Shared types and codes for the buffered UART FIFO pair with echo.
`default_nettype none

package ubfe_pkg;

   localparam logic [2:0] CMD_RX_BYTE  = 3'd0;
   localparam logic [2:0] CMD_GET      = 3'd1;
   localparam logic [2:0] CMD_PUT      = 3'd2;
   localparam logic [2:0] CMD_TX_READY = 3'd3;
   localparam logic [2:0] CMD_RX_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_OVERRUN = 2'd3;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic [1:0] status;
      logic       tx_byte_valid;
      logic       rx_available;
      logic       tx_request;
      logic       overrun_flag;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/uart_buffered_fifo_pair_echo.sv
// Top level of the buffered UART FIFO pair with receive echo.
`default_nettype none

// An item is taken whenever start is high and busy is low; busy is high only in
// the cycle after reset, so one item enters per clock. Each item gives exactly
// one result, shown with rsp_strobe in the cycle after acceptance; the receiver
// cannot stall, so it must take every result in that cycle. Both FIFOs live in
// one-port-write, one-port-read RAMs of BUFFER_DEPTH bytes with registered
// read data; a pop reads at the accept edge and its byte appears with the
// result. The echo enable register, echo_ff, is written through the csr
// channel, which is always ready.
module uart_buffered_fifo_pair_echo
   import ubfe_pkg::*;
#(
   parameter int BUFFER_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   localparam int PW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);
   localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_DEPTH - 1);
   localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(BUFFER_DEPTH);

   function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
      next_pos = (p == LAST_POS) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] oldest_pos(input logic [PW-1:0] ins,
                                                input logic [CW-1:0] cnt);
      logic [CW:0] sum;
      sum = (CW + 1)'(ins) + DEPTH_X - (CW + 1)'(cnt);
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      oldest_pos = sum[PW-1:0];
   endfunction

   logic          busy_ff;
   logic          echo_ff;
   logic [PW-1:0] tx_insert_ff, tx_insert_in;
   logic [CW-1:0] tx_count_ff, tx_count_in;
   logic [PW-1:0] rx_insert_ff, rx_insert_in;
   logic [CW-1:0] rx_count_ff, rx_count_in;
   logic          tx_irq_ff, tx_irq_in;
   logic          overrun_ff, overrun_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          sel_rx_ff, sel_rx_in;
   logic          sel_tx_ff, sel_tx_in;

   logic          go;
   logic          tx_wr_en, rx_wr_en, tx_rd_en, rx_rd_en;
   logic [PW-1:0] tx_rd_addr, rx_rd_addr;
   logic [7:0]    tx_rd_data, rx_rd_data;

   assign go        = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      tx_insert_in = tx_insert_ff;
      tx_count_in  = tx_count_ff;
      rx_insert_in = rx_insert_ff;
      rx_count_in  = rx_count_ff;
      tx_irq_in    = tx_irq_ff;
      overrun_in   = overrun_ff;
      tx_wr_en     = 1'b0;
      rx_wr_en     = 1'b0;
      tx_rd_en     = 1'b0;
      rx_rd_en     = 1'b0;
      tx_rd_addr   = oldest_pos(tx_insert_ff, tx_count_ff);
      rx_rd_addr   = oldest_pos(rx_insert_ff, rx_count_ff);
      sel_rx_in    = 1'b0;
      sel_tx_in    = 1'b0;
      rsp_in       = '0;
      if (go) begin
         case (req_data.command)
            CMD_RX_BYTE: begin
               if (echo_ff && tx_count_ff != DEPTH_C) begin
                  tx_wr_en     = 1'b1;
                  tx_insert_in = next_pos(tx_insert_ff);
                  tx_count_in  = tx_count_ff + CW'(1);
                  tx_irq_in    = 1'b1;
               end
               if (rx_count_ff == DEPTH_C) begin
                  overrun_in    = 1'b1;
                  rsp_in.status = ST_OVERRUN;
               end else begin
                  rx_wr_en     = 1'b1;
                  rx_insert_in = next_pos(rx_insert_ff);
                  rx_count_in  = rx_count_ff + CW'(1);
               end
            end
            CMD_GET: begin
               if (rx_count_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rx_rd_en    = 1'b1;
                  sel_rx_in   = 1'b1;
                  rx_count_in = rx_count_ff - CW'(1);
               end
            end
            CMD_PUT: begin
               if (tx_count_ff == DEPTH_C) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  tx_wr_en     = 1'b1;
                  tx_insert_in = next_pos(tx_insert_ff);
                  tx_count_in  = tx_count_ff + CW'(1);
                  tx_irq_in    = 1'b1;
               end
            end
            CMD_TX_READY: begin
               if (tx_count_ff == '0) begin
                  tx_irq_in     = 1'b0;
                  rsp_in.status = ST_EMPTY;
               end else begin
                  tx_rd_en             = 1'b1;
                  sel_tx_in            = 1'b1;
                  tx_count_in          = tx_count_ff - CW'(1);
                  rsp_in.tx_byte_valid = 1'b1;
               end
            end
            CMD_RX_CLEAR: begin
               rx_insert_in = '0;
               rx_count_in  = '0;
            end
            default: begin
            end
         endcase
         rsp_in.rx_available = (rx_count_in != '0);
         rsp_in.tx_request   = tx_irq_in;
         rsp_in.overrun_flag = overrun_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         echo_ff      <= 1'b0;
         tx_insert_ff <= '0;
         tx_count_ff  <= '0;
         rx_insert_ff <= '0;
         rx_count_ff  <= '0;
         tx_irq_ff    <= 1'b0;
         overrun_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_rx_ff    <= 1'b0;
         sel_tx_ff    <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         if (csr_valid && csr_ready) begin
            echo_ff <= csr_data;
         end
         tx_insert_ff <= tx_insert_in;
         tx_count_ff  <= tx_count_in;
         rx_insert_ff <= rx_insert_in;
         rx_count_ff  <= rx_count_in;
         tx_irq_ff    <= tx_irq_in;
         overrun_ff   <= overrun_in;
         rsp_valid_ff <= go;
         sel_rx_ff    <= sel_rx_in;
         sel_tx_ff    <= sel_tx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   ubfe_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_insert_ff),
      .wr_data (req_data.data_in),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   ubfe_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_insert_ff),
      .wr_data (req_data.data_in),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   always_comb begin
      rsp_data = rsp_ff;
      if (sel_rx_ff) begin
         rsp_data.data_out = rx_rd_data;
      end else if (sel_tx_ff) begin
         rsp_data.data_out = tx_rd_data;
      end else begin
         rsp_data.data_out = '0;
      end
   end

   assign rsp_strobe = rsp_valid_ff;

   a_tx_count_bound: assert property (@(posedge clock) disable iff (reset)
      tx_count_ff <= DEPTH_C)
      else $error("tx count above depth");

   a_rx_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= DEPTH_C)
      else $error("rx count above depth");

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(sel_rx_ff && sel_tx_ff))
      else $error("both FIFOs selected for one item");

   a_item_result: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("accepted item gave no result");

   a_tx_pop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.tx_byte_valid |-> sel_tx_ff && rsp_ff.status == ST_OK)
      else $error("transmit pop with bad status");

endmodule

`default_nettype wire

>>> hw/rtl/ubfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ubfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
